// ===== hdl/srv_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo registry package
// Shared codes, widths and helper functions for the servo registry block.
// ----------------------------------------------------------------------------
package srv_pkg;

	localparam int SRV_TABLE_ENTRIES = 8;

	localparam int ID_W      = 8;
	localparam int PORT_W    = 4;
	localparam int ENTRY_W   = ID_W + PORT_W;
	localparam int ANGLE_W   = 16;
	localparam int RANGE_W   = 9;
	localparam int DIVIDEND_W = 20;
	localparam int QUOT_W    = 11;
	localparam int PULSE_W   = 12;
	localparam int RECIP_W   = 21;
	localparam int RECIP_SHIFT = 17;

	localparam logic [RANGE_W-1:0]  RANGE_180      = 9'd180;
	localparam logic [RANGE_W-1:0]  RANGE_270      = 9'd270;
	localparam logic [RANGE_W-1:0]  RANGE_300      = 9'd300;
	localparam logic [DIVIDEND_W-1:0] PULSE_SPAN_US = 20'd2000;
	localparam logic [PULSE_W-1:0]  PULSE_BASE_US  = 12'd500;

	// Scale factors ceil(2000 * 2^17 / range). For any angle up to the range
	// the rounding error stays below 2^17, so the product shifted right by
	// 17 equals the truncated quotient angle * 2000 / range.
	localparam logic [RECIP_W-1:0]  RECIP_180      = 21'd1456356;
	localparam logic [RECIP_W-1:0]  RECIP_270      = 21'd970904;
	localparam logic [RECIP_W-1:0]  RECIP_300      = 21'd873814;

	typedef enum logic [1:0] {
		CMD_REGISTER  = 2'd0,
		CMD_ANGLE_180 = 2'd1,
		CMD_ANGLE_270 = 2'd2,
		CMD_ANGLE_300 = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_DUP     = 2'd2,
		STAT_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// Angle range of the servo type selected by an angle command.
	function automatic logic [RANGE_W-1:0] range_of(input cmd_t c);
		logic [RANGE_W-1:0] r;
		case (c)
			CMD_ANGLE_180: r = RANGE_180;
			CMD_ANGLE_270: r = RANGE_270;
			default:       r = RANGE_300;
		endcase
		return r;
	endfunction

	// Pulse span scale factor of the servo type selected by an angle command.
	function automatic logic [RECIP_W-1:0] recip_of(input cmd_t c);
		logic [RECIP_W-1:0] m;
		case (c)
			CMD_ANGLE_180: m = RECIP_180;
			CMD_ANGLE_270: m = RECIP_270;
			default:       m = RECIP_300;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/srv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srv_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/srv_div.sv =====
// ----------------------------------------------------------------------------
// Servo pulse scaler
// Computes angle*span/range by multiplying with a fixed-point reciprocal.
// ----------------------------------------------------------------------------
module srv_div (
	input  logic                             clk,
	input  logic                             start,
	input  logic [srv_pkg::RANGE_W-1:0]      angle,
	input  logic [srv_pkg::RECIP_W-1:0]      recip,
	output logic [srv_pkg::QUOT_W-1:0]       quotient
);
	import srv_pkg::*;

	localparam int PROD_W = RANGE_W + RECIP_W;

	logic [PROD_W-1:0] product;
	logic [QUOT_W-1:0] quo_q;

	// The angle is already clamped to the range, so the product stays below
	// 2^28 and the quotient fits in QUOT_W bits.
	assign product = PROD_W'(angle) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= product[RECIP_SHIFT +: QUOT_W];
		end
	end

	assign quotient = quo_q;

endmodule

// ===== hdl/servo_registry_angle_to_pulse.sv =====
// ----------------------------------------------------------------------------
// Servo registry with angle to pulse width conversion
// Keeps a table of servo ids and their PWM ports in a RAM and turns angle
// requests into pulse widths for the registered port.
// ----------------------------------------------------------------------------
// Processing: a table scan issues N reads at one a cycle, N being the number
// of entries, then waits for the last read data to be compared and leaves
// the scan; an empty table issues no reads. The finish step waits for the
// output register to be free. The next request is taken while the previous
// result still waits in the output register.
// Reset: arst_n clears the entry count and all control state; the table RAM
// is not cleared, since only entries below the count are ever read.
module servo_registry_angle_to_pulse #(
	parameter int TABLE_ENTRIES = srv_pkg::SRV_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  servo_id,
	input  logic [1:0]  timer_index,
	input  logic [1:0]  channel_index,
	input  logic [15:0] angle_deg,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        pulse_valid,
	output logic [1:0]  out_timer,
	output logic [1:0]  out_channel,
	output logic [11:0] pulse_width
);
	import srv_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	// Control state.
	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_idx_q;
	logic          pend_s1;
	logic          hit_q;
	logic          out_valid_q;

	// Request held for the duration of its processing.
	cmd_t               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [PORT_W-1:0]  port_q;
	logic [PORT_W-1:0]  hit_port_q;

	// Output register.
	logic [1:0]         status_q;
	logic               pulse_valid_q;
	logic [1:0]         out_timer_q;
	logic [1:0]         out_channel_q;
	logic [PULSE_W-1:0] pulse_width_q;

	// Combinational controls.
	logic               accept;
	logic               scan_issue;
	logic               rd_en;
	logic               wr_en;
	logic               load_out;
	logic               full;
	logic               is_reg;
	logic [ENTRY_W-1:0] rd_data;

	// Pulse scaler interface.
	logic                  div_start;
	logic [QUOT_W-1:0]     quotient;
	logic [RANGE_W-1:0]    in_range;
	logic [RECIP_W-1:0]    in_recip;
	logic [RANGE_W-1:0]    angle_clamped;

	// Result fields before they enter the output register.
	status_t            res_status;
	logic               res_pv;
	logic [PORT_W-1:0]  res_port;
	logic [PULSE_W-1:0] res_pulse;

	assign accept = in_valid && in_ready;
	assign full   = (count_q == CW'(TABLE_ENTRIES));
	assign is_reg = (cmd_q == CMD_REGISTER);

	// The angle conversion does not depend on the table, so the scaled value
	// is registered right at acceptance and is ready before the scan ends.
	assign in_range      = range_of(cmd_t'(cmd));
	assign in_recip      = recip_of(cmd_t'(cmd));
	assign angle_clamped = (angle_deg > {{(ANGLE_W-RANGE_W){1'b0}}, in_range}) ?
	                       in_range : angle_deg[RANGE_W-1:0];
	assign div_start     = accept && (cmd_t'(cmd) != CMD_REGISTER);

	srv_div u_div (
		.clk      (clk),
		.start    (div_start),
		.angle    (angle_clamped),
		.recip    (in_recip),
		.quotient (quotient)
	);

	// Table of {servo id, port}. Reads walk the valid entries in order of
	// registration; the only write appends at the current count.
	srv_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({id_q, port_q}),
		.rd_en   (rd_en),
		.rd_addr (issue_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Next state and controls. A scan issues one read per cycle until every
	// valid entry has been read, then waits for the last read data to be
	// compared. The finish step waits for the output register to be free.
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		load_out   = 1'b0;
		scan_issue = (issue_idx_q < count_q);
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				rd_en = scan_issue;
				if (!scan_issue && !pend_s1) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					wr_en    = is_reg && !full && !hit_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result of the request. A full table is reported ahead of a duplicate.
	always_comb begin
		res_status = STAT_OK;
		res_pv     = 1'b0;
		res_port   = '0;
		res_pulse  = '0;
		if (is_reg) begin
			if (full) begin
				res_status = STAT_FULL;
			end else if (hit_q) begin
				res_status = STAT_DUP;
			end
		end else if (hit_q) begin
			res_pv    = 1'b1;
			res_port  = hit_port_q;
			res_pulse = PULSE_BASE_US + PULSE_W'(quotient);
		end else begin
			res_status = STAT_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_idx_q <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (accept) begin
				issue_idx_q <= '0;
				hit_q       <= 1'b0;
			end else begin
				if (rd_en) begin
					issue_idx_q <= issue_idx_q + 1'b1;
				end
				if (pend_s1 && (rd_data[ENTRY_W-1:PORT_W] == id_q)) begin
					hit_q <= 1'b1;
				end
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(cmd);
			id_q   <= servo_id;
			port_q <= {timer_index, channel_index};
		end
		if (pend_s1 && (rd_data[ENTRY_W-1:PORT_W] == id_q)) begin
			hit_port_q <= rd_data[PORT_W-1:0];
		end
		if (load_out) begin
			status_q      <= res_status;
			pulse_valid_q <= res_pv;
			out_timer_q   <= res_port[3:2];
			out_channel_q <= res_port[1:0];
			pulse_width_q <= res_pulse;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign pulse_valid = pulse_valid_q;
	assign out_timer   = out_timer_q;
	assign out_channel = out_channel_q;
	assign pulse_width = pulse_width_q;

endmodule

// ===== hdl/srv_checker.sv =====
// ----------------------------------------------------------------------------
// Servo registry port checker
// Watches the top level ports for result consistency and handshake behavior.
// ----------------------------------------------------------------------------
module srv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        pulse_valid,
	input logic [1:0]  out_timer,
	input logic [1:0]  out_channel,
	input logic [11:0] pulse_width
);
	import srv_pkg::*;

	// A pending result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(pulse_valid) && $stable(pulse_width))
		else $error("result changed while stalled");

	// An issued pulse carries an ok status and a width in the legal window.
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_valid |-> status == STAT_OK &&
		pulse_width >= 12'd500 && pulse_width <= 12'd2500)
		else $error("issued pulse out of range");

	// Results without a pulse carry all-zero port and width fields.
	a_no_pulse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pulse_valid |-> pulse_width == 12'd0 &&
		out_timer == 2'd0 && out_channel == 2'd0)
		else $error("stray pulse fields");

	// Requests are processed one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

endmodule

bind servo_registry_angle_to_pulse srv_checker u_srv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.pulse_valid (pulse_valid),
	.out_timer   (out_timer),
	.out_channel (out_channel),
	.pulse_width (pulse_width)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Servo registry testbench
// Drives register and angle requests into the servo registry over the
// valid/ready request channel. Each accepted request goes through a
// predictor that keeps its own copy of the servo table. Each result taken
// from the output channel is compared field by field with the oldest
// predicted result. Both sides of the block are throttled at random in
// the first two of three phases.
// ----------------------------------------------------------------------------
module tb;
	import srv_pkg::*;

	// Generous ceiling on the run. The slowest legal run is about 1200
	// requests, each paying the table scan, the sender's longest gap and
	// the receiver's longest stall, and stays well under this ceiling.
	localparam int CYCLE_LIMIT = 600000;
	// Idle cycles allowed after the last expected result has arrived. This
	// covers the table scan of a full table with margin, so a stray
	// extra result would still be seen.
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_REQUESTS = 400;

	// One result as the block should present it.
	typedef struct {
		status_t     status;
		logic        pulse_valid;
		logic [1:0]  timer;
		logic [1:0]  channel;
		logic [11:0] pulse_width;
	} pulse_result_t;

	// Keeps a private image of the servo table. It turns every accepted
	// request into the result the block must return, and holds those
	// results in arrival order until the block returns them.
	class servo_table_model;
		logic [ID_W-1:0] ids[SRV_TABLE_ENTRIES];
		logic [1:0]      timers[SRV_TABLE_ENTRIES];
		logic [1:0]      channels[SRV_TABLE_ENTRIES];
		int              entries;
		pulse_result_t   pending_pulses[$];
		int              failures;

		function new();
			entries = 0;
			failures = 0;
		endfunction

		function int lookup(logic [ID_W-1:0] id);
			for (int i = 0; i < entries; i++) begin
				if (ids[i] == id)
					return i;
			end
			return -1;
		endfunction

		// Any id that is currently in the table; the caller ensures entries > 0.
		function logic [ID_W-1:0] known_id();
			return ids[$urandom_range(0, entries - 1)];
		endfunction

		function void take_request(cmd_t c, logic [7:0] id, logic [1:0] tim,
				logic [1:0] chn, logic [15:0] angle);
			pulse_result_t r;
			int hit;
			int span;
			int clamped;
			r.status = STAT_OK;
			r.pulse_valid = 1'b0;
			r.timer = 2'd0;
			r.channel = 2'd0;
			r.pulse_width = 12'd0;
			hit = lookup(id);
			if (c == CMD_REGISTER) begin
				// A full table is reported even when the id is a duplicate.
				if (entries >= SRV_TABLE_ENTRIES) begin
					r.status = STAT_FULL;
				end else if (hit >= 0) begin
					r.status = STAT_DUP;
				end else begin
					ids[entries] = id;
					timers[entries] = tim;
					channels[entries] = chn;
					entries++;
				end
			end else begin
				case (c)
					CMD_ANGLE_180: span = int'(RANGE_180);
					CMD_ANGLE_270: span = int'(RANGE_270);
					default:       span = int'(RANGE_300);
				endcase
				clamped = (int'(angle) > span) ? span : int'(angle);
				if (hit < 0) begin
					r.status = STAT_UNKNOWN;
				end else begin
					r.pulse_valid = 1'b1;
					r.timer = timers[hit];
					r.channel = channels[hit];
					r.pulse_width = 12'(int'(PULSE_BASE_US) +
						clamped * int'(PULSE_SPAN_US) / span);
				end
			end
			pending_pulses.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, name, want, got);
				failures++;
			end
		endfunction

		function void check_response(logic [1:0] st, logic pv, logic [1:0] tm,
				logic [1:0] ch, logic [11:0] pw);
			pulse_result_t e;
			if (pending_pulses.size() == 0) begin
				$display("%0t: result with no request pending: status %0d pulse %0d",
					$time, st, pw);
				failures++;
				return;
			end
			e = pending_pulses.pop_front();
			compare_field("status", int'(e.status), int'(st));
			compare_field("pulse_valid", int'(e.pulse_valid), int'(pv));
			compare_field("out_timer", int'(e.timer), int'(tm));
			compare_field("out_channel", int'(e.channel), int'(ch));
			compare_field("pulse_width", int'(e.pulse_width), int'(pw));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_REGISTER;
	logic [7:0]  servo_id = 8'd0;
	logic [1:0]  timer_index = 2'd0;
	logic [1:0]  channel_index = 2'd0;
	logic [15:0] angle_deg = 16'd0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        pulse_valid;
	logic [1:0]  out_timer;
	logic [1:0]  out_channel;
	logic [11:0] pulse_width;

	// Percent chance, per cycle, that the sender holds off a request or the
	// receiver refuses a result. The stimulus process changes these between
	// phases.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int cycle_count = 0;

	servo_table_model board;

	servo_registry_angle_to_pulse DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.servo_id      (servo_id),
		.timer_index   (timer_index),
		.channel_index (channel_index),
		.angle_deg     (angle_deg),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.pulse_valid   (pulse_valid),
		.out_timer     (out_timer),
		.out_channel   (out_channel),
		.pulse_width   (pulse_width)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side. All signals are read just after the rising edge, before
	// any nonblocking update lands, so they hold the values the block saw at
	// that edge. out_ready is then redrawn for the next cycle.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready)
			board.check_response(status, pulse_valid, out_timer, out_channel,
				pulse_width);
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Presents one request and returns at the edge where it is accepted.
	// Random idle cycles may come first. When there are none, valid stays
	// high straight through from the previous request, so it gets just one
	// assignment in that time step.
	task automatic send_request(input cmd_t c, input logic [7:0] id,
			input logic [1:0] tim, input logic [1:0] chn, input logic [15:0] angle);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		servo_id <= id;
		timer_index <= tim;
		channel_index <= chn;
		angle_deg <= angle;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		board.take_request(c, id, tim, chn, angle);
	endtask

	// Most random traffic is angle requests to servos already in the table.
	// The angle is drawn in range, at or just past the range edges, or over
	// the full 16-bit span. The rest probes unknown ids and registration;
	// registration keeps hitting the full and duplicate cases once the table
	// has filled up.
	task automatic random_request();
		int pick;
		int flavor;
		int span;
		cmd_t c;
		logic [7:0] id;
		logic [15:0] angle;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_request(CMD_REGISTER, 8'($urandom_range(0, 255)),
				2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				16'($urandom_range(0, 65535)));
		end else begin
			c = cmd_t'($urandom_range(1, 3));
			span = (c == CMD_ANGLE_180) ? 180 : (c == CMD_ANGLE_270) ? 270 : 300;
			if (pick < 85 && board.entries > 0)
				id = board.known_id();
			else
				id = 8'($urandom_range(0, 255));
			flavor = $urandom_range(0, 3);
			case (flavor)
				0, 1: angle = 16'($urandom_range(0, span));
				2: begin
					case ($urandom_range(0, 2))
						0: angle = 16'd0;
						1: angle = 16'(span);
						default: angle = 16'(span + 1);
					endcase
				end
				default: angle = 16'($urandom_range(0, 65535));
			endcase
			send_request(c, id, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), angle);
		end
	endtask

	initial begin
		board = new();
		sender_idle_pct = 29;
		receiver_stall_pct = 87;

		// Reset is held low from the start and released at an edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An angle request on the empty table comes first.
		// Then registrations with the extreme ids and ports follow. The
		// register requests carry odd angles, which the block must ignore.
		send_request(CMD_ANGLE_180, 8'h07, 2'd0, 2'd0, 16'd90);
		send_request(CMD_REGISTER, 8'h00, 2'd0, 2'd0, 16'hFFFF);
		send_request(CMD_REGISTER, 8'hFF, 2'd3, 2'd3, 16'h0000);
		send_request(CMD_REGISTER, 8'h5A, 2'd1, 2'd2, 16'hAAAA);
		send_request(CMD_REGISTER, 8'hA5, 2'd2, 2'd1, 16'h5555);
		// Registering an id that is already present must be refused.
		send_request(CMD_REGISTER, 8'hFF, 2'd0, 2'd1, 16'd0);
		// The 180 type at zero; every servo type at the exact range and clamped from above.
		send_request(CMD_ANGLE_180, 8'h00, 2'd0, 2'd0, 16'd0);
		send_request(CMD_ANGLE_180, 8'hFF, 2'd0, 2'd0, 16'd180);
		send_request(CMD_ANGLE_270, 8'h5A, 2'd0, 2'd0, 16'd270);
		send_request(CMD_ANGLE_300, 8'hA5, 2'd0, 2'd0, 16'd300);
		send_request(CMD_ANGLE_300, 8'hFF, 2'd0, 2'd0, 16'hFFFF);
		send_request(CMD_ANGLE_270, 8'h00, 2'd0, 2'd0, 16'd271);
		send_request(CMD_ANGLE_180, 8'h5A, 2'd0, 2'd0, 16'd181);
		send_request(CMD_ANGLE_180, 8'hA5, 2'd3, 2'd3, 16'd179);
		send_request(CMD_ANGLE_300, 8'h00, 2'd0, 2'd0, 16'd299);
		// A lookup miss with a table that is not empty.
		send_request(CMD_ANGLE_270, 8'h33, 2'd0, 2'd0, 16'd100);
		send_request(CMD_ANGLE_270, 8'hA5, 2'd0, 2'd0, 16'hAAAA);
		send_request(CMD_ANGLE_180, 8'hFF, 2'd0, 2'd0, 16'h5555);
		// Fill the table. A full table wins over the duplicate check.
		send_request(CMD_REGISTER, 8'h01, 2'd1, 2'd0, 16'd0);
		send_request(CMD_REGISTER, 8'h02, 2'd0, 2'd3, 16'd0);
		send_request(CMD_REGISTER, 8'h03, 2'd2, 2'd2, 16'd0);
		send_request(CMD_REGISTER, 8'h04, 2'd3, 2'd1, 16'd0);
		send_request(CMD_REGISTER, 8'h09, 2'd1, 2'd1, 16'd0);
		send_request(CMD_REGISTER, 8'hFF, 2'd1, 2'd1, 16'd0);
		// The last entry of a full table must still be found.
		send_request(CMD_ANGLE_300, 8'h04, 2'd0, 2'd0, 16'd150);

		// Random part in three phases; the last one has no throttling.
		repeat (PHASE_REQUESTS) random_request();
		sender_idle_pct = 87;
		receiver_stall_pct = 29;
		repeat (PHASE_REQUESTS) random_request();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (PHASE_REQUESTS) random_request();
		in_valid <= 1'b0;

		// Drain the outstanding results, then watch a little longer for
		// anything extra.
		while (board.pending_pulses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/srv_pkg.sv
hdl/srv_ram.sv
hdl/srv_div.sv
hdl/servo_registry_angle_to_pulse.sv
hdl/srv_checker.sv
tb/sv/tb.sv
